/* src/tlkc_pkg.sv */
package tlkc_pkg;

  // input op codes
  localparam logic [1:0] OP_PIXEL      = 2'd0;
  localparam logic [1:0] OP_FRAME_DONE = 2'd1;
  localparam logic [1:0] OP_RESTART    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_BACK_RED       = 3'd0;
  localparam logic [2:0] REG_BACK_GREEN     = 3'd1;
  localparam logic [2:0] REG_BACK_BLUE      = 3'd2;
  localparam logic [2:0] REG_TINT_RED       = 3'd3;
  localparam logic [2:0] REG_TINT_GREEN     = 3'd4;
  localparam logic [2:0] REG_TINT_BLUE      = 3'd5;
  localparam logic [2:0] REG_TIMELINE_MODE  = 3'd6;
  localparam logic [2:0] REG_FRAMES_IN_CLIP = 3'd7;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CLIP_W     = 16;

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][7:0] rgb8_t;
  typedef logic signed [17:0] prod_t;
  typedef prod_t [2:0] rgb_prod_t;

  // start colour of the timeline tint ramp
  localparam rgb8_t TL_BASE    = {8'd255, 8'd105, 8'd23};
  localparam rgb8_t TINT_RESET = {8'd255, 8'd105, 8'd23};

  localparam logic [4:0] MASK5 = 5'h1F;
  localparam logic [5:0] MASK6 = 6'h3F;
  localparam int unsigned MAX5 = 31;
  localparam int unsigned MAX6 = 63;

  // rounded-up reciprocals, exact over the c * 255 range
  localparam int unsigned RCP31 = ((1 << 18) + MAX5 - 1) / MAX5;
  localparam int unsigned RCP63 = ((1 << 20) + MAX6 - 1) / MAX6;

  // frame counter sequencer
  typedef enum logic {
    FC_IDLE,
    FC_DIV
  } fc_state_e;

  // 5-bit channel widened to 8 bits, truncated
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] p;
    logic [25:0] q;
    p = {c, 8'h00} - 13'(c);
    q = 26'(p) * 26'(RCP31);
    return q[25:18];
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] p;
    logic [27:0] q;
    p = {c, 8'h00} - 14'(c);
    q = 28'(p) * 28'(RCP63);
    return q[27:20];
  endfunction

  // (to - from) * mix
  function automatic prod_t mix_mul(input logic [7:0] from, input logic [7:0] to,
                                    input logic [7:0] mix);
    logic signed [8:0] diff;
    diff = $signed({1'b0, to}) - $signed({1'b0, from});
    return 18'(diff * $signed({1'b0, mix}));
  endfunction

  // from + p / 255, quotient truncated toward zero; |p| stays below 2^16
  function automatic logic [7:0] mix_add(input logic [7:0] from, input prod_t p);
    logic [16:0] mag;
    logic [16:0] q;
    mag = p[17] ? 17'(-p) : 17'(p);
    q   = (mag + (mag >> 8) + 17'd1) >> 8;
    return p[17] ? 8'(from - q[7:0]) : 8'(from + q[7:0]);
  endfunction

endpackage

/* src/tlkc_frame_ctr.sv */
module tlkc_frame_ctr
  import tlkc_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  clear_i,
  input  logic [CLIP_W-1:0]     clip_i,
  output logic [FRAME_BITS-1:0] frame_o,
  output logic                  busy_o
);

  localparam int unsigned NW   = FRAME_BITS + 1;
  localparam int unsigned CMPW = (NW > CLIP_W) ? NW : CLIP_W;
  localparam int unsigned CNTW = $clog2(NW + 1);

  fc_state_e state_q, state_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [NW-1:0]         dvd_q, dvd_d;
  logic [CLIP_W-1:0]     rem_q, rem_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;

  logic [NW-1:0]     n;
  logic [CMPW-1:0]   n_ext, clip_ext;
  logic              slow;
  logic              last;
  logic [CLIP_W:0]   trial;
  logic [CLIP_W:0]   trial_sub;
  logic [CLIP_W-1:0] rem_nx;

  assign n        = {1'b0, frame_q} + NW'(1);
  assign n_ext    = CMPW'(n);
  assign clip_ext = CMPW'(clip_i);
  assign slow     = step_i && (clip_i != '0) && (n_ext > clip_ext);
  assign last     = (cnt_q == CNTW'(NW - 1));

  // one restoring remainder step per cycle
  assign trial     = {rem_q, dvd_q[NW-1]};
  assign trial_sub = trial - {1'b0, clip_i};
  assign rem_nx    = (trial >= {1'b0, clip_i}) ? trial_sub[CLIP_W-1:0] : trial[CLIP_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      FC_IDLE: begin
        if (slow) state_d = FC_DIV;
      end
      FC_DIV: begin
        if (last) state_d = FC_IDLE;
      end
      default: state_d = FC_IDLE;
    endcase
  end

  always_comb begin
    busy_o = 1'b0;
    case (state_q)
      FC_IDLE: busy_o = 1'b0;
      FC_DIV:  busy_o = 1'b1;
      default: busy_o = 1'b0;
    endcase
  end

  always_comb begin
    frame_d = frame_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    if (state_q == FC_DIV) begin
      dvd_d = dvd_q << 1;
      rem_d = rem_nx;
      cnt_d = cnt_q + CNTW'(1);
      if (last) frame_d = FRAME_BITS'(rem_nx);
    end else if (clear_i) begin
      frame_d = '0;
    end else if (step_i && (clip_i != '0)) begin
      if (slow) begin
        dvd_d = n;
        rem_d = '0;
        cnt_d = '0;
      end else if (n_ext == clip_ext) begin
        frame_d = '0;
      end else begin
        frame_d = n[FRAME_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FC_IDLE;
      frame_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      frame_q <= frame_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign frame_o = frame_q;

endmodule

/* src/tinted_luma_key_compositor.sv */
// pipeline: an accepted pixel beat runs through every stage register to the output register
// throughput: one beat per cycle unless the output stalls; a frame-done beat whose
//   next frame number passes the clip length holds the input in the remainder unit
// reset: asynchronous, active low; clears the pipeline, frame number and registers
//   (tint resets to 23,105,255, all else to zero)
module tinted_luma_key_compositor
  import tlkc_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input beats
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            op_i,
  input  logic [15:0]           pixel_in_i,
  // result beats
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           pixel_out_o
);

  // configuration registers
  rgb8_t             back_q;
  rgb8_t             tint_q;
  logic              timeline_q;
  logic [CLIP_W-1:0] clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_q     <= '0;
      tint_q     <= TINT_RESET;
      timeline_q <= 1'b0;
      clip_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_BACK_RED:       back_q[0]  <= cfg_wdata_i[7:0];
        REG_BACK_GREEN:     back_q[1]  <= cfg_wdata_i[7:0];
        REG_BACK_BLUE:      back_q[2]  <= cfg_wdata_i[7:0];
        REG_TINT_RED:       tint_q[0]  <= cfg_wdata_i[7:0];
        REG_TINT_GREEN:     tint_q[1]  <= cfg_wdata_i[7:0];
        REG_TINT_BLUE:      tint_q[2]  <= cfg_wdata_i[7:0];
        REG_TIMELINE_MODE:  timeline_q <= cfg_wdata_i[0];
        REG_FRAMES_IN_CLIP: clip_q     <= cfg_wdata_i[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline flow control
  logic in_acc;
  logic busy;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // a stage takes new data when it is empty or the stage after it moves on
  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o = rdy1 && !busy;
  assign in_acc     = in_valid_i && in_ready_o;

  // frame counter sits at the input so every pixel sees all earlier frame beats
  logic [FRAME_BITS-1:0] frame;

  tlkc_frame_ctr #(
    .FRAME_BITS(FRAME_BITS)
  ) u_frame_ctr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_acc && (op_i == OP_FRAME_DONE)),
    .clear_i (in_acc && (op_i == OP_RESTART)),
    .clip_i  (clip_q),
    .frame_o (frame),
    .busy_o  (busy)
  );

  // timeline mix curve: ramp up over frames 1-8, hold, ramp down over 59-66
  logic [3:0]  ramp_k;
  logic [6:0]  down_k;
  logic [11:0] ramp_p;
  logic [7:0]  mix;

  assign down_k = 7'd66 - frame[6:0];

  always_comb begin
    ramp_k = 4'd0;
    mix    = 8'd0;
    if (frame == '0) begin
      mix = 8'd0;
    end else if (frame <= FRAME_BITS'(8)) begin
      ramp_k = frame[3:0];
      mix    = ramp_p[10:3];
    end else if (frame <= FRAME_BITS'(58)) begin
      mix = 8'd255;
    end else if (frame <= FRAME_BITS'(66)) begin
      ramp_k = down_k[3:0];
      mix    = ramp_p[10:3];
    end
  end

  // k * 255
  assign ramp_p = {ramp_k, 8'h00} - 12'(ramp_k);

  // stage 1: source pixel and frame mix
  logic [15:0] px1_q;
  logic [7:0]  m1_q;

  // stage 2: widened channels folded to alpha, tint ramp products
  logic [7:0] lum2_q;
  rgb_prod_t  pt2_q;

  // stage 3: effective tint
  logic [7:0] lum3_q;
  rgb8_t      e3_q;

  // stage 4: blend products over the background
  rgb_prod_t  p4_q;

  // stage 5: packed result, the output register
  logic [15:0] pix5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_acc && (op_i == OP_PIXEL);
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  logic [7:0] r_x, g_x, b_x, lum_rg, lum_x;
  rgb8_t      e_x;
  rgb8_t      o_x;

  assign r_x    = expand5(px1_q[15:11] & MASK5);
  assign g_x    = expand6(px1_q[10:5] & MASK6);
  assign b_x    = expand5(px1_q[4:0] & MASK5);
  assign lum_rg = (r_x > g_x) ? r_x : g_x;
  assign lum_x  = (b_x > lum_rg) ? b_x : lum_rg;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e_x[c] = timeline_q ? mix_add(TL_BASE[c], pt2_q[c]) : tint_q[c];
      o_x[c] = mix_add(back_q[c], p4_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && rdy1) begin
      px1_q <= pixel_in_i;
      m1_q  <= mix;
    end
    if (v1_q && rdy2) begin
      lum2_q <= lum_x;
      for (int c = 0; c < 3; c++) pt2_q[c] <= mix_mul(TL_BASE[c], tint_q[c], m1_q);
    end
    if (v2_q && rdy3) begin
      lum3_q <= lum2_q;
      e3_q   <= e_x;
    end
    if (v3_q && rdy4) begin
      for (int c = 0; c < 3; c++) p4_q[c] <= mix_mul(back_q[c], e3_q[c], lum3_q);
    end
    if (v4_q && rdy5) begin
      // drop low bits back to 5/6/5
      pix5_q <= {o_x[0][7:3], o_x[1][7:2], o_x[2][7:3]};
    end
  end

  assign out_valid_o = v5_q;
  assign pixel_out_o = pix5_q;

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlkc_pkg::*;

  // op code 3 has no meaning: the block takes the beat and drops it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES   = 5;
  // pipeline latency plus a full remainder pass of the frame counter, with margin
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_SHOWN      = 10;
  localparam int LONG_HOLD      = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [15:0] pixel_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] pixel_out_o;

  tinted_luma_key_compositor #(
    .FRAME_BITS(16)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .pixel_in_i (pixel_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o)
  );

  // shadow copy of the registers and the frame counter
  logic [7:0]  back_r, back_g, back_b;
  logic [7:0]  tint_r, tint_g, tint_b;
  logic        ramp_on;
  logic [15:0] clip_len;
  logic [15:0] frame_q;

  // composited pixels still owed by the block, oldest first
  logic [15:0] pixel_exp_q[$];
  logic [15:0] pixel_want;

  int fail_count;
  int stall_cycles;
  int hold_left;
  int ready_gap;
  bit idle_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // from + (to - from) * a / 255, signed division truncates toward zero
  function automatic logic [7:0] blend8(input logic [7:0] from, input logic [7:0] to,
                                        input logic [7:0] a);
    int diff;
    int step;
    diff = int'(to) - int'(from);
    step = diff * int'(a) / 255;
    return 8'(int'(from) + step);
  endfunction

  // tint mix along the clip: ramp up, hold, ramp down, then off
  function automatic logic [7:0] ramp_mix(input logic [15:0] f);
    int unsigned fv;
    fv = f;
    if (fv == 0) return 8'd0;
    if (fv <= 8) return 8'(fv * 255 / 8);
    if (fv <= 58) return 8'd255;
    if (fv <= 66) return 8'((66 - fv) * 255 / 8);
    return 8'd0;
  endfunction

  function automatic logic [15:0] composite_pixel(input logic [15:0] px);
    logic [7:0] tr, tg, tbl;
    logic [7:0] r8, g8, b8, a8;
    logic [7:0] mr, mg, mb;
    logic [7:0] m;
    tr  = tint_r;
    tg  = tint_g;
    tbl = tint_b;
    if (ramp_on) begin
      m   = ramp_mix(frame_q);
      tr  = blend8(TL_BASE[0], tint_r, m);
      tg  = blend8(TL_BASE[1], tint_g, m);
      tbl = blend8(TL_BASE[2], tint_b, m);
    end
    r8 = 8'(int'(px[15:11]) * 255 / 31);
    g8 = 8'(int'(px[10:5]) * 255 / 63);
    b8 = 8'(int'(px[4:0]) * 255 / 31);
    // brightest channel keys the tint
    a8 = (r8 > g8) ? r8 : g8;
    if (b8 > a8) a8 = b8;
    mr = blend8(back_r, tr, a8);
    mg = blend8(back_g, tg, a8);
    mb = blend8(back_b, tbl, a8);
    return {mr[7:3], mg[7:2], mb[7:3]};
  endfunction

  // advance the shadow state for one accepted input beat
  task automatic track_beat(input logic [1:0] op, input logic [15:0] px);
    case (op)
      OP_PIXEL: pixel_exp_q.push_back(composite_pixel(px));
      OP_FRAME_DONE: begin
        // counter stops at clip length zero; a frame past the clip wraps here
        if (clip_len != 16'd0) frame_q = 16'((32'(frame_q) + 32'd1) % 32'(clip_len));
      end
      OP_RESTART: frame_q = 16'd0;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // register write, only ever issued while the block is empty
  task automatic set_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_BACK_RED:       back_r   = data[7:0];
      REG_BACK_GREEN:     back_g   = data[7:0];
      REG_BACK_BLUE:      back_b   = data[7:0];
      REG_TINT_RED:       tint_r   = data[7:0];
      REG_TINT_GREEN:     tint_g   = data[7:0];
      REG_TINT_BLUE:      tint_b   = data[7:0];
      REG_TIMELINE_MODE:  ramp_on  = data[0];
      REG_FRAMES_IN_CLIP: clip_len = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // whole register set; junk in the unused upper bits must be dropped
  task automatic load_setting(input logic [7:0] br, input logic [7:0] bgr,
                              input logic [7:0] bb, input logic [7:0] tr,
                              input logic [7:0] tg, input logic [7:0] tbl,
                              input logic mode, input logic [15:0] clip);
    set_reg(REG_BACK_RED,       {8'($urandom), br});
    set_reg(REG_BACK_GREEN,     {8'($urandom), bgr});
    set_reg(REG_BACK_BLUE,      {8'($urandom), bb});
    set_reg(REG_TINT_RED,       {8'($urandom), tr});
    set_reg(REG_TINT_GREEN,     {8'($urandom), tg});
    set_reg(REG_TINT_BLUE,      {8'($urandom), tbl});
    set_reg(REG_TIMELINE_MODE,  {15'($urandom), mode});
    set_reg(REG_FRAMES_IN_CLIP, clip);
  endtask

  // offer one input beat and hold it until the block takes it
  task automatic send_beat(input logic [1:0] op, input logic [15:0] px);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    pixel_in_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    track_beat(op, px);
  endtask

  // stop offering, wait for every owed pixel, then let the frame counter settle
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixel_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {5'($urandom), 11'd0};
      3: return {5'd0, 6'($urandom), 5'd0};
      4: return {11'd0, 5'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  // frames of random pixels closed by frame done, with some restarts and noise
  task automatic run_stream(input int n_items, input int restart_permil);
    int sent;
    int burst;
    int kind;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 999);
      if (kind < restart_permil) begin
        send_beat(OP_RESTART, 16'($urandom));
        sent++;
      end else if (kind < restart_permil + 40) begin
        // noise: lone beats in any order, the unused code included
        case ($urandom_range(0, 2))
          0: send_beat(OP_UNUSED, 16'($urandom));
          1: begin
            send_beat(OP_FRAME_DONE, 16'($urandom));
            sent++;
          end
          default: begin
            send_beat(OP_PIXEL, pick_pixel());
            sent++;
          end
        endcase
      end else begin
        burst = $urandom_range(1, 4);
        repeat (burst) send_beat(OP_PIXEL, pick_pixel());
        send_beat(OP_FRAME_DONE, 16'($urandom));
        sent += burst + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: black background, default tint, plain mode
  task automatic test_reset_defaults();
    send_beat(OP_PIXEL, 16'h0000);
    send_beat(OP_PIXEL, 16'hFFFF);
    send_beat(OP_PIXEL, 16'hF800);
    send_beat(OP_PIXEL, 16'h07E0);
    send_beat(OP_PIXEL, 16'h001F);
    send_beat(OP_PIXEL, 16'h0821);
    drain_block();
  endtask

  // black tint over a white background and mixed extremes, so the blend runs downward too
  task automatic test_blend_extremes();
    load_setting(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0);
    send_beat(OP_PIXEL, 16'hFFFF);
    send_beat(OP_PIXEL, 16'h0000);
    send_beat(OP_PIXEL, 16'h8410);
    send_beat(OP_PIXEL, 16'h7BEF);
    drain_block();
    load_setting(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0, 16'd0);
    send_beat(OP_PIXEL, 16'hFFFF);
    send_beat(OP_PIXEL, 16'h1000);
    drain_block();
  endtask

  // frame done with wrap, restart, the unused code, and a stopped counter
  task automatic test_frame_ops();
    load_setting(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128, 1'b1, 16'd3);
    send_beat(OP_PIXEL, 16'hFFFF);
    send_beat(OP_FRAME_DONE, 16'h0000);
    send_beat(OP_PIXEL, 16'hFFFF);
    send_beat(OP_FRAME_DONE, 16'hFFFF);
    send_beat(OP_FRAME_DONE, 16'h0000);
    send_beat(OP_PIXEL, 16'hFFFF);
    send_beat(OP_FRAME_DONE, 16'h0000);
    send_beat(OP_RESTART, 16'hFFFF);
    send_beat(OP_PIXEL, 16'hFFFF);
    send_beat(OP_UNUSED, 16'hFFFF);
    send_beat(OP_PIXEL, 16'h8410);
    send_beat(OP_FRAME_DONE, 16'h0000);
    drain_block();
    set_reg(REG_FRAMES_IN_CLIP, 16'd0);
    send_beat(OP_FRAME_DONE, 16'h0000);
    send_beat(OP_PIXEL, 16'hFFFF);
    drain_block();
  endtask

  // run the counter far, then shrink the clip below it so the next frame done wraps
  task automatic test_clip_shrink();
    load_setting(pick_level(), pick_level(), pick_level(), pick_level(), pick_level(),
                 pick_level(), 1'b1, 16'd200);
    send_beat(OP_RESTART, 16'($urandom));
    repeat (90) begin
      if ($urandom_range(0, 1) == 0) send_beat(OP_PIXEL, pick_pixel());
      send_beat(OP_FRAME_DONE, 16'($urandom));
    end
    drain_block();
    set_reg(REG_FRAMES_IN_CLIP, 16'($urandom_range(2, 20)));
    run_stream(60, 5);
    drain_block();
  endtask

  // random settings per phase; timeline phases restart rarely so the ramp is walked
  task automatic test_random_phases();
    logic        mode;
    logic [15:0] clip;
    for (int ph = 0; ph < 4; ph++) begin
      mode = ph[0];
      if (mode) begin
        clip = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(67, 90));
      end else begin
        case ($urandom_range(0, 4))
          0: clip = 16'd0;
          1: clip = 16'd1;
          2: clip = 16'hFFFF;
          default: clip = 16'($urandom_range(2, 100));
        endcase
      end
      load_setting(pick_level(), pick_level(), pick_level(), pick_level(), pick_level(),
                   pick_level(), mode, clip);
      if (ph == 2) begin
        // sender waits for every owed pixel mid phase
        run_stream(150, 60);
        drain_block();
        run_stream(150, 60);
      end else begin
        run_stream(300, mode ? 5 : 60);
      end
      drain_block();
    end
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_long_hold();
    load_setting(pick_level(), pick_level(), pick_level(), pick_level(), pick_level(),
                 pick_level(), 1'b1, 16'd80);
    run_stream(60, 5);
    hold_left = LONG_HOLD;
    run_stream(140, 5);
    drain_block();
  endtask

  // closing stretch at full rate on both sides
  task automatic test_quiet_tail();
    idle_on = 1'b0;
    load_setting(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 16'd70);
    run_stream(300, 5);
    drain_block();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus the long hold when asked
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (ready_gap > 0) begin
        out_ready_i <= 1'b0;
        ready_gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        ready_gap = $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest owed pixel
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_exp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
          $display("pixel beat %h with nothing owed at %0t", pixel_out_o, $time);
        end
      end else begin
        pixel_want = pixel_exp_q.pop_front();
        if (pixel_out_o !== pixel_want) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("pixel_out mismatch at %0t: expected %h, got %h",
                     $time, pixel_want, pixel_out_o);
          end
        end
      end
    end
  end

  // watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_addr_i   = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    op_i         = OP_PIXEL;
    pixel_in_i   = '0;
    out_ready_i  = 1'b0;
    fail_count   = 0;
    stall_cycles = 0;
    hold_left    = 0;
    ready_gap    = 0;
    idle_on      = 1'b1;
    // shadow state after reset
    back_r   = 8'd0;
    back_g   = 8'd0;
    back_b   = 8'd0;
    tint_r   = TINT_RESET[0];
    tint_g   = TINT_RESET[1];
    tint_b   = TINT_RESET[2];
    ramp_on  = 1'b0;
    clip_len = 16'd0;
    frame_q  = 16'd0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_blend_extremes();
    test_frame_ops();
    test_clip_shrink();
    test_random_phases();
    test_long_hold();
    test_quiet_tail();

    // anything still owed is a lost pixel
    if (pixel_exp_q.size() != 0) begin
      $display("%0d pixels never came out", pixel_exp_q.size());
      fail_count += pixel_exp_q.size();
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
